[hw/rtl/lrc_pkg.sv]
// Shared types and constants for the LRU key cache.
// Used by lrc_cell and lru_cache_replacement_top; depends on nothing else.
package lrc_pkg;

   // Field widths that the request and response formats fix.
   localparam int KEY_WIDTH    = 16;
   localparam int SLOT_W       = 4;
   localparam int COUNT_W      = 32;
   localparam int CSR_W        = 5;

   // Default cache size and the widest index or age any legal size needs.
   localparam int WAYS_DEFAULT = 16;
   localparam int IDX_MAX_W    = 6;

   // Size register value after reset.
   localparam logic [CSR_W-1:0] WAYS_IN_USE_RESET = CSR_W'(16);

   typedef struct packed {
      logic [KEY_WIDTH-1:0] ref_key;
      logic                 end_of_run;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic                 evicted_valid;
      logic [KEY_WIDTH-1:0] evicted_key;
      logic [COUNT_W-1:0]   hit_count;
      logic [COUNT_W-1:0]   miss_count;
   } rsp_type;

   // Search wave that travels one cell per cycle down the chain.
   typedef struct packed {
      logic                 found;
      logic [IDX_MAX_W-1:0] found_idx;
      logic [IDX_MAX_W-1:0] found_age;
      logic                 any;
      logic [IDX_MAX_W-1:0] best_idx;
      logic [IDX_MAX_W-1:0] best_age;
      logic [KEY_WIDTH-1:0] best_key;
   } scan_type;

   // Lookup key and write-back decision sent to every cell at once.
   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic                 upd_en;
      logic                 hit;
      logic [IDX_MAX_W-1:0] slot;
      logic [IDX_MAX_W-1:0] hit_age;
      logic                 clear;
   } bcast_type;

endpackage

[hw/rtl/lru_cache_replacement_top.sv]
// Top level of the fully associative LRU key cache: control, counters, cell chain.
// Depends on lrc_pkg and lrc_cell.

// Each request looks one key up in a fully associative cache of WAYS entries with
// least-recently-used replacement, and returns one response: hit or miss, the entry
// used, the evicted key if a valid entry was replaced, and saturating hit and miss
// counts for the current run. The entries sit in a chain of cells, and the search
// travels down that chain one cell per clock: a request is taken, its search wave
// passes every cell and leaves the last one, and then the decision is written back
// to every cell and the response is registered. req_stall is low only between
// requests, and a new request is taken while an earlier response still waits to
// be collected; the block only holds its write-back when that response has not yet
// gone. The size register (csr_wdata) selects how many entries are in use, from 1
// to WAYS; zero acts as one and larger values act as WAYS. A request with end_of_run
// set gets its normal response, after which all valid bits, ages, the fill count
// and both counters clear, while stored keys stay. The size register should only be
// written while no request is in flight; it resets to 16.
module lru_cache_replacement_top #(
   parameter int WAYS = lrc_pkg::WAYS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lrc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lrc_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lrc_pkg::CSR_W-1:0]  csr_wdata
);
   import lrc_pkg::*;

   // Wide enough for the size register, for WAYS itself and for every cell index.
   localparam int CNT_BITS = $clog2(WAYS + 1);
   localparam int M_W      = (CNT_BITS > CSR_W) ? CNT_BITS : CSR_W;

   typedef enum logic [0:0] {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type            state_ff, state_in;
   logic [M_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [M_W-1:0]       fill_ff, fill_in;
   logic [CSR_W-1:0]     ways_ff, ways_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 last_ff, last_in;
   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   scan_type             chain [0:WAYS];
   scan_type             tail;
   bcast_type            bcast;
   logic [WAYS-1:0]      in_use;

   logic [M_W-1:0]       ways_ext;
   logic [M_W-1:0]       m_eff;
   logic                 full;
   logic                 req_accept;
   logic                 scan_done;
   logic                 finish;
   logic                 dec_hit;
   logic [IDX_MAX_W-1:0] dec_slot;
   logic                 ev_valid;
   logic [COUNT_W-1:0]   hit_cnt_upd;
   logic [COUNT_W-1:0]   miss_cnt_upd;

   // The search wave enters the chain empty every cycle.
   assign chain[0] = '0;

   for (genvar i = 0; i < WAYS; i++) begin : g_cell
      assign in_use[i] = (M_W'(i) < m_eff);

      lrc_cell #(
         .WAYS  (WAYS),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_use    (in_use[i]),
         .bcast     (bcast),
         .scan_prev (chain[i]),
         .scan_next (chain[i+1])
      );
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      tail = chain[WAYS];

      // Effective size clamped to the range 1 .. WAYS.
      ways_ext = M_W'(ways_ff);
      if (ways_ext == '0) begin
         m_eff = M_W'(1);
      end else if (ways_ext > M_W'(WAYS)) begin
         m_eff = M_W'(WAYS);
      end else begin
         m_eff = ways_ext;
      end
      // A cache that was shrunk below its fill count counts as full.
      full = (fill_ff >= m_eff);

      // The key is held until the count reaches WAYS, so the last cell then holds the whole search.
      scan_done = (state_ff == S_SCAN) && (scan_cnt_ff == M_W'(WAYS));
      finish    = scan_done && (!rsp_valid_ff || !rsp_stall);

      dec_hit = tail.found;
      if (dec_hit) begin
         dec_slot = tail.found_idx;
      end else if (!full) begin
         dec_slot = IDX_MAX_W'(fill_ff);
      end else if (tail.any) begin
         dec_slot = tail.best_idx;
      end else begin
         dec_slot = '0;
      end
      ev_valid = !dec_hit && full && tail.any;

      hit_cnt_upd  = hit_cnt_ff;
      miss_cnt_upd = miss_cnt_ff;
      if (dec_hit && (hit_cnt_ff != '1)) begin
         hit_cnt_upd = hit_cnt_ff + COUNT_W'(1);
      end
      if (!dec_hit && (miss_cnt_ff != '1)) begin
         miss_cnt_upd = miss_cnt_ff + COUNT_W'(1);
      end

      bcast.key     = key_ff;
      bcast.upd_en  = finish;
      bcast.hit     = dec_hit;
      bcast.slot    = dec_slot;
      bcast.hit_age = tail.found_age;
      bcast.clear   = finish && last_ff;

      rsp_data_in.hit           = dec_hit;
      rsp_data_in.slot          = dec_slot[SLOT_W-1:0];
      rsp_data_in.evicted_valid = ev_valid;
      rsp_data_in.evicted_key   = ev_valid ? tail.best_key : '0;
      rsp_data_in.hit_count     = hit_cnt_upd;
      rsp_data_in.miss_count    = miss_cnt_upd;

      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      fill_in      = fill_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ways_in      = (csr_valid && csr_ready) ? csr_wdata : ways_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in      = req_data.ref_key;
               last_in     = req_data.end_of_run;
               scan_cnt_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!scan_done) begin
               scan_cnt_in = scan_cnt_ff + M_W'(1);
            end else if (finish) begin
               rsp_valid_in = 1'b1;
               hit_cnt_in   = hit_cnt_upd;
               miss_cnt_in  = miss_cnt_upd;
               if (!dec_hit && !full) begin
                  fill_in = fill_ff + M_W'(1);
               end
               if (last_ff) begin
                  fill_in     = '0;
                  hit_cnt_in  = '0;
                  miss_cnt_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_cnt_ff  <= '0;
         fill_ff      <= '0;
         ways_ff      <= WAYS_IN_USE_RESET;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         fill_ff      <= fill_in;
         ways_ff      <= ways_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff  <= key_in;
      last_ff <= last_in;
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   // The fill count never passes the number of cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= M_W'(WAYS))
      else $error("fill count exceeds the number of entries");

   // A taken request always starts a fresh search.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_SCAN) && (scan_cnt_ff == '0))
      else $error("request taken without starting a search");

   // Write-back always produces a pending response.
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("write-back without a response");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.evicted_valid))
      else $error("hit response reports an evicted key");
`endif

endmodule

[hw/rtl/lrc_cell.sv]
// One cache entry of the LRU key cache: key, valid bit, age and a search stage.
// Depends on lrc_pkg.
module lrc_cell #(
   parameter int WAYS  = lrc_pkg::WAYS_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_use,
   input  lrc_pkg::bcast_type bcast,
   input  lrc_pkg::scan_type  scan_prev,
   output lrc_pkg::scan_type  scan_next
);
   import lrc_pkg::*;

   localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);
   localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 valid_ff, valid_in;
   logic [AGE_W-1:0]     age_ff, age_in;
   scan_type             scan_ff, scan_in;

   logic                 match;
   logic                 better;
   logic [AGE_W-1:0]     age_up;

   always_comb begin
      match  = in_use && valid_ff && (key_ff == bcast.key);
      better = in_use && valid_ff &&
               (!scan_prev.any || (IDX_MAX_W'(age_ff) > scan_prev.best_age));
      age_up = (age_ff < AGE_MAX) ? age_ff + AGE_W'(1) : AGE_MAX;

      // The first match along the chain wins; later cells pass it on.
      scan_in = scan_prev;
      if (!scan_prev.found && match) begin
         scan_in.found     = 1'b1;
         scan_in.found_idx = MY_IDX;
         scan_in.found_age = IDX_MAX_W'(age_ff);
      end
      // Strictly older only, so ties keep the lower-numbered entry.
      if (better) begin
         scan_in.any      = 1'b1;
         scan_in.best_idx = MY_IDX;
         scan_in.best_age = IDX_MAX_W'(age_ff);
         scan_in.best_key = key_ff;
      end

      key_in   = key_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      if (bcast.upd_en) begin
         if (bcast.slot == MY_IDX) begin
            age_in = '0;
            if (!bcast.hit) begin
               key_in   = bcast.key;
               valid_in = 1'b1;
            end
         end else if (in_use && valid_ff &&
                      (!bcast.hit || (IDX_MAX_W'(age_ff) < bcast.hit_age))) begin
            age_in = age_up;
         end
         if (bcast.clear) begin
            valid_in = 1'b0;
            age_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
      end
      key_ff  <= key_in;
      scan_ff <= scan_in;
   end

   assign scan_next = scan_ff;

endmodule

[bench/tb_lru_cache_replacement_top.sv]
// Self-checking bench for the fully associative LRU key cache, top level only.
// Needs lrc_pkg and lru_cache_replacement_top; the behavior is predicted in this file.
`timescale 1ns / 1ps

module tb_lru_cache_replacement_top;
   import lrc_pkg::*;

   localparam int WAYS  = WAYS_DEFAULT;
   localparam int AGE_W = $clog2(WAYS);
   // Time for one request to pass through the block; waits before a size write use this.
   localparam int LOOKUP_CYCLES = WAYS + 2;
   localparam int PHASE_LOOKUPS = 150;
   localparam int PHASES        = 8;

   // One row of the directed table: either a size write or a lookup request.
   // Rows with typed_in set carry a response worked out by hand; the rest are
   // checked against the predictor below.
   typedef struct {
      bit                is_size_write;
      logic [CSR_W-1:0]  size_value;
      req_type           req;
      bit                typed_in;
      rsp_type           want;
   } stim_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata = WAYS_IN_USE_RESET;

   // Predictor copy of the cache: keys, valid bits, ages, fill level, size and counters.
   logic [KEY_WIDTH-1:0] line_key   [WAYS];
   logic                 line_valid [WAYS];
   logic [AGE_W-1:0]     line_age   [WAYS];
   logic [CSR_W:0]       fill_level;
   logic [CSR_W-1:0]     size_reg;
   logic [COUNT_W-1:0]   run_hits;
   logic [COUNT_W-1:0]   run_misses;

   // Responses still owed by the block, oldest first.
   rsp_type pending_lookups[$];

   int  mismatch_total = 0;
   int  lookups_sent   = 0;
   int  hits_seen      = 0;
   int  evictions_seen = 0;
   int  run_ends_seen  = 0;
   int  size_writes    = 0;
   int  stall_left     = 0;
   // While set, neither side idles, so requests go back to back.
   bit  steady         = 1'b0;

   stim_row_type         directed_rows[$];
   logic [KEY_WIDTH-1:0] key_pool[64];
   int                   pool_n;
   int                   live;
   logic [CSR_W-1:0]     phase_size;

   lru_cache_replacement_top #(.WAYS(WAYS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ends a hung run.
   initial begin
      #6000000;
      $display("Test completed with failures");
      $finish;
   end

   // Clears everything that an end-of-run request clears; the stored keys stay.
   function automatic void clear_run_state();
      for (int i = 0; i < WAYS; i++) begin
         line_valid[i] = 1'b0;
         line_age[i]   = '0;
      end
      fill_level = '0;
      run_hits   = '0;
      run_misses = '0;
   endfunction

   // Looks one key up in the predictor's cache, updates recency, fill level and
   // counters the way the block should, and returns the response it must send.
   function automatic rsp_type lookup_and_update(req_type r);
      rsp_type          res;
      int               in_use;
      int               slot_i;
      bit               found;
      bit               have_victim;
      logic [AGE_W-1:0] oldest;
      res         = '0;
      slot_i      = 0;
      found       = 1'b0;
      have_victim = 1'b0;
      oldest      = '0;
      // A size of zero acts as one; anything above WAYS acts as WAYS.
      in_use = (size_reg == 0) ? 1 : ((size_reg > WAYS) ? WAYS : int'(size_reg));

      // Lowest-numbered matching entry wins when the key sits in more than one.
      for (int i = 0; i < in_use; i++) begin
         if (!found && line_valid[i] && line_key[i] == r.ref_key) begin
            found  = 1'b1;
            slot_i = i;
         end
      end

      if (found) begin
         // Only entries younger than the hit one grow older.
         for (int i = 0; i < in_use; i++) begin
            if (i != slot_i && line_valid[i] && line_age[i] < line_age[slot_i])
               line_age[i] = (line_age[i] < WAYS - 1) ? line_age[i] + 1'b1 : AGE_W'(WAYS - 1);
         end
         line_age[slot_i] = '0;
         if (run_hits != '1)
            run_hits = run_hits + 1'b1;
      end else begin
         if (fill_level < in_use) begin
            slot_i     = int'(fill_level);
            fill_level = fill_level + 1'b1;
         end else begin
            // Full, or shrunk below the fill level: replace the oldest entry,
            // taking the lowest-numbered one among equal ages.
            for (int i = 0; i < in_use; i++) begin
               if (line_valid[i] && (!have_victim || line_age[i] > oldest)) begin
                  oldest      = line_age[i];
                  slot_i      = i;
                  have_victim = 1'b1;
               end
            end
            if (have_victim) begin
               res.evicted_valid = 1'b1;
               res.evicted_key   = line_key[slot_i];
            end
         end
         for (int i = 0; i < in_use; i++) begin
            if (i != slot_i && line_valid[i])
               line_age[i] = (line_age[i] < WAYS - 1) ? line_age[i] + 1'b1 : AGE_W'(WAYS - 1);
         end
         line_key[slot_i]   = r.ref_key;
         line_valid[slot_i] = 1'b1;
         line_age[slot_i]   = '0;
         if (run_misses != '1)
            run_misses = run_misses + 1'b1;
      end

      res.hit        = found;
      res.slot       = SLOT_W'(slot_i);
      res.hit_count  = run_hits;
      res.miss_count = run_misses;
      if (r.end_of_run)
         clear_run_state();
      return res;
   endfunction

   function automatic stim_row_type size_row(logic [CSR_W-1:0] v);
      stim_row_type row;
      row               = '{default: '0};
      row.is_size_write = 1'b1;
      row.size_value    = v;
      return row;
   endfunction

   function automatic stim_row_type lookup_row(logic [KEY_WIDTH-1:0] key, logic last);
      stim_row_type row;
      row                = '{default: '0};
      row.req.ref_key    = key;
      row.req.end_of_run = last;
      return row;
   endfunction

   function automatic stim_row_type checked_row(logic [KEY_WIDTH-1:0] key, logic last,
                                                logic hit, int slot_n, logic ev,
                                                logic [KEY_WIDTH-1:0] ev_key,
                                                int hits, int misses);
      stim_row_type row;
      row                    = lookup_row(key, last);
      row.typed_in           = 1'b1;
      row.want.hit           = hit;
      row.want.slot          = SLOT_W'(slot_n);
      row.want.evicted_valid = ev;
      row.want.evicted_key   = ev_key;
      row.want.hit_count     = COUNT_W'(hits);
      row.want.miss_count    = COUNT_W'(misses);
      return row;
   endfunction

   // Presents one lookup request and holds it until the block takes it. The
   // expected response is worked out at the accepting edge, so it always sees
   // the size that was in force for that request. When keep_valid is set and
   // no idle gap is drawn, valid simply stays high for the next request.
   task automatic issue_lookup(req_type r, bit typed_in, rsp_type want, bit keep_valid);
      rsp_type predicted;
      bit      idle_now;
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      predicted = lookup_and_update(r);
      pending_lookups.push_back(typed_in ? want : predicted);
      lookups_sent++;
      hits_seen      += predicted.hit;
      evictions_seen += predicted.evicted_valid;
      run_ends_seen  += r.end_of_run;
      idle_now = !steady && ($urandom_range(99) < 10);
      if (!keep_valid || idle_now)
         req_valid <= 1'b0;
      if (idle_now)
         repeat ($urandom_range(1, 24)) @(posedge clock);
   endtask

   // The size may only change while the block is idle, so every owed response
   // is collected first and the block gets a full lookup time to settle.
   task automatic write_cache_size(logic [CSR_W-1:0] v);
      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (LOOKUP_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = v;
      size_writes++;
   endtask

   // Response side: stalls about one cycle in twenty, now and then for a long
   // stretch, so the block has to hold its write-back at every point.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(99) < 5) begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(99) < 5) ? $urandom_range(10, 40) : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every response taken is compared with the oldest one owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("%0t: response with no request owed: %s", $realtime,
                        $sformatf("hit=%0b slot=%0d ev=%0b/%h hits=%0d misses=%0d",
                                  rsp_data.hit, rsp_data.slot, rsp_data.evicted_valid,
                                  rsp_data.evicted_key, rsp_data.hit_count,
                                  rsp_data.miss_count));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.slot !== want.slot ||
                rsp_data.evicted_valid !== want.evicted_valid ||
                rsp_data.evicted_key !== want.evicted_key ||
                rsp_data.hit_count !== want.hit_count ||
                rsp_data.miss_count !== want.miss_count) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("%0t: mismatch: expected %s", $realtime,
                           $sformatf("hit=%0b slot=%0d ev=%0b/%h hits=%0d misses=%0d",
                                     want.hit, want.slot, want.evicted_valid,
                                     want.evicted_key, want.hit_count, want.miss_count));
                  $display("%0t: mismatch: got      %s", $realtime,
                           $sformatf("hit=%0b slot=%0d ev=%0b/%h hits=%0d misses=%0d",
                                     rsp_data.hit, rsp_data.slot, rsp_data.evicted_valid,
                                     rsp_data.evicted_key, rsp_data.hit_count,
                                     rsp_data.miss_count));
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < WAYS; i++)
         line_key[i] = '0;
      clear_run_state();
      size_reg = WAYS_IN_USE_RESET;

      // Directed part. The first rows run at the reset size: two fills, a hit,
      // and an end-of-run hit after which the counters and valid bits clear.
      directed_rows.push_back(checked_row(16'h0000, 1'b0, 1'b0, 0, 1'b0, 16'h0000, 0, 1));
      directed_rows.push_back(checked_row(16'hFFFF, 1'b0, 1'b0, 1, 1'b0, 16'h0000, 0, 2));
      directed_rows.push_back(checked_row(16'h0000, 1'b0, 1'b1, 0, 1'b0, 16'h0000, 1, 2));
      directed_rows.push_back(checked_row(16'hFFFF, 1'b1, 1'b1, 1, 1'b0, 16'h0000, 2, 2));
      // The key stays stored but is no longer valid, so this misses into entry 0.
      directed_rows.push_back(checked_row(16'hFFFF, 1'b0, 1'b0, 0, 1'b0, 16'h0000, 0, 1));
      // A size of zero acts as one entry, which is already full.
      directed_rows.push_back(size_row(5'd0));
      directed_rows.push_back(checked_row(16'h1234, 1'b0, 1'b0, 0, 1'b1, 16'hFFFF, 0, 2));
      directed_rows.push_back(checked_row(16'h1234, 1'b0, 1'b1, 0, 1'b0, 16'h0000, 1, 2));
      directed_rows.push_back(checked_row(16'hABCD, 1'b0, 1'b0, 0, 1'b1, 16'h1234, 1, 3));
      // The largest register value acts as the full cache; filling resumes at entry 1.
      directed_rows.push_back(size_row(5'd31));
      directed_rows.push_back(checked_row(16'hABCD, 1'b0, 1'b1, 0, 1'b0, 16'h0000, 2, 3));
      directed_rows.push_back(checked_row(16'h5555, 1'b0, 1'b0, 1, 1'b0, 16'h0000, 2, 4));
      // Three entries: fill, replace the oldest, refresh one, replace again.
      directed_rows.push_back(size_row(5'd3));
      directed_rows.push_back(lookup_row(16'h0F0F, 1'b0));
      directed_rows.push_back(lookup_row(16'h00F0, 1'b0));
      directed_rows.push_back(lookup_row(16'h5555, 1'b0));
      directed_rows.push_back(lookup_row(16'h1111, 1'b0));
      // Shrinking to one entry stores a key that already sits higher up, so at
      // full size it is found twice and the lower entry must answer.
      directed_rows.push_back(size_row(5'd1));
      directed_rows.push_back(lookup_row(16'h5555, 1'b0));
      directed_rows.push_back(size_row(5'd16));
      directed_rows.push_back(lookup_row(16'h5555, 1'b0));
      directed_rows.push_back(lookup_row(16'h8000, 1'b0));
      directed_rows.push_back(lookup_row(16'h7FFF, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_size_write)
            write_cache_size(directed_rows[i].size_value);
         else
            issue_lookup(directed_rows[i].req, directed_rows[i].typed_in,
                         directed_rows[i].want,
                         (i + 1 < directed_rows.size()) && !directed_rows[i + 1].is_size_write);
      end

      // Random part: each phase picks a size, then draws most keys from a small
      // pool a little larger than the cache, so hits, fills and evictions all
      // happen often. One key in ten is fully random, and a few requests end
      // the run. The size write at each phase start also makes the sender wait
      // until every owed response is in.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_size = 5'd16;
            1: phase_size = 5'd1;
            2: phase_size = 5'd0;
            3: phase_size = 5'd31;
            4: phase_size = 5'd17;
            5: phase_size = 5'd2;
            6: phase_size = 5'd8;
            default: phase_size = CSR_W'($urandom_range(0, 31));
         endcase
         write_cache_size(phase_size);
         // Phase 6 runs with no idling on either side.
         steady = (phase == 6);
         live   = (phase_size == 0) ? 1 : ((phase_size > WAYS) ? WAYS : int'(phase_size));
         pool_n = live + $urandom_range(1, live + 2);
         for (int k = 0; k < pool_n; k++)
            key_pool[k] = KEY_WIDTH'($urandom);
         for (int n = 0; n < PHASE_LOOKUPS; n++) begin
            req_type r;
            r.ref_key    = ($urandom_range(99) < 10) ? KEY_WIDTH'($urandom)
                                                     : key_pool[$urandom_range(0, pool_n - 1)];
            r.end_of_run = ($urandom_range(99) < 2);
            issue_lookup(r, 1'b0, '0, n + 1 < PHASE_LOOKUPS);
         end
      end
      steady = 1'b0;

      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (LOOKUP_CYCLES) @(posedge clock);

      $display("Ran %0d lookups over %0d size settings (zero, one, full and oversize).",
               lookups_sent, size_writes);
      $display("They gave %0d hits, %0d evictions and %0d run ends; %0d responses were wrong.",
               hits_seen, evictions_seen, run_ends_seen, mismatch_total);
      if (mismatch_total == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
